/* rtl/bcc_pkg.sv */
package bcc_pkg;

  localparam int unsigned MsW     = 16;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CodeW-1:0] ST_BOOT     = 3'd0;
  localparam logic [CodeW-1:0] ST_IDLE     = 3'd1;
  localparam logic [CodeW-1:0] ST_PRESSED  = 3'd2;
  localparam logic [CodeW-1:0] ST_LONG     = 3'd3;
  localparam logic [CodeW-1:0] ST_EXTRA    = 3'd4;
  localparam logic [CodeW-1:0] ST_RELEASED = 3'd5;
  localparam logic [CodeW-1:0] ST_DOUBLE   = 3'd6;

  typedef enum logic [CodeW-1:0] {
    EV_NONE        = 3'd0,
    EV_SINGLE      = 3'd1,
    EV_DOUBLE      = 3'd2,
    EV_LONG_REACH  = 3'd3,
    EV_EXTRA_REACH = 3'd4,
    EV_LONG_REL    = 3'd5,
    EV_EXTRA_REL   = 3'd6
  } click_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENABLE     = 3'd0,
    REG_DEBOUNCE   = 3'd1,
    REG_DOUBLE_GAP = 3'd2,
    REG_LONG       = 3'd3,
    REG_EXTRA      = 3'd4
  } cfg_reg_e;

  localparam logic [MsW-1:0] DebounceRst  = 16'd50;
  localparam logic [MsW-1:0] DoubleGapRst = 16'd200;
  localparam logic [MsW-1:0] LongRst      = 16'd2000;
  localparam logic [MsW-1:0] ExtraRst     = 16'd3000;

  typedef struct packed {
    logic           enable;
    logic [MsW-1:0] debounce_ms;
    logic [MsW-1:0] double_gap_ms;
    logic [MsW-1:0] long_ms;
    logic [MsW-1:0] extra_ms;
  } cfg_t;

endpackage

/* rtl/bcc_regs.sv */
module bcc_regs import bcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [MsW-1:0]     cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENABLE:     cfg_d.enable        = cfg_wdata_i[0];
        REG_DEBOUNCE:   cfg_d.debounce_ms   = cfg_wdata_i;
        REG_DOUBLE_GAP: cfg_d.double_gap_ms = cfg_wdata_i;
        REG_LONG:       cfg_d.long_ms       = cfg_wdata_i;
        REG_EXTRA:      cfg_d.extra_ms      = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= 1'b0;
      cfg_q.debounce_ms   <= DebounceRst;
      cfg_q.double_gap_ms <= DoubleGapRst;
      cfg_q.long_ms       <= LongRst;
      cfg_q.extra_ms      <= ExtraRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/bcc_core.sv */
module bcc_core import bcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             pin_level_i,
  input  cfg_t             cfg_i,
  output logic [CodeW-1:0] click_event_o,
  output logic [CodeW-1:0] button_state_o
);

  logic [CodeW-1:0] phase_q, phase_d;
  logic [MsW-1:0]   elapsed_q, elapsed_d;
  logic [MsW-1:0]   elapsed_inc;
  logic             settled;
  click_event_e     ev;

  // saturating tick count
  assign elapsed_inc = (elapsed_q == {MsW{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
  assign settled     = elapsed_inc >= cfg_i.debounce_ms;

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    ev        = EV_NONE;
    if (cfg_i.enable) begin
      elapsed_d = elapsed_inc;
      unique case (phase_q)
        ST_BOOT: begin
          if (!pin_level_i) begin
            phase_d = ST_IDLE; elapsed_d = '0;
          end
        end
        ST_IDLE: begin
          if (settled && pin_level_i) begin
            phase_d = ST_PRESSED; elapsed_d = '0;
          end
        end
        ST_PRESSED: begin
          if (settled) begin
            if (!pin_level_i) begin
              phase_d = ST_RELEASED; elapsed_d = '0;
            end else if (elapsed_inc >= cfg_i.long_ms) begin
              ev = EV_LONG_REACH; phase_d = ST_LONG; elapsed_d = '0;
            end
          end
        end
        ST_LONG: begin
          if (!pin_level_i) begin
            ev = EV_LONG_REL; phase_d = ST_IDLE; elapsed_d = '0;
          end else if (elapsed_inc >= cfg_i.extra_ms) begin
            ev = EV_EXTRA_REACH; phase_d = ST_EXTRA; elapsed_d = '0;
          end
        end
        ST_EXTRA: begin
          if (!pin_level_i) begin
            ev = EV_EXTRA_REL; phase_d = ST_IDLE; elapsed_d = '0;
          end
        end
        ST_RELEASED: begin
          if (settled) begin
            if (pin_level_i) begin
              ev = EV_DOUBLE; phase_d = ST_DOUBLE; elapsed_d = '0;
            end else if (elapsed_inc >= cfg_i.double_gap_ms) begin
              ev = EV_SINGLE; phase_d = ST_IDLE; elapsed_d = '0;
            end
          end
        end
        ST_DOUBLE: begin
          if (settled && !pin_level_i) begin
            phase_d = ST_IDLE; elapsed_d = '0;
          end
        end
        default: begin
          phase_d = ST_IDLE; elapsed_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ST_BOOT;
      elapsed_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign click_event_o  = ev;
  assign button_state_o = phase_d;

endmodule

/* rtl/button_click_classifier.sv */
// Accepted beats pass an input register, then the classifier, then a result register.
// Throughput: one beat per cycle unless the result side stalls.
// The update (increment, four compares, next state) fits between the two registers.
// Reset (rst_ni low, async): classifier to boot, count to zero, disabled, default
// timing registers, both pipeline registers empty.
module button_click_classifier import bcc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [MsW-1:0]     cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               pin_level_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CodeW-1:0]   click_event_o,
  output logic [CodeW-1:0]   button_state_o
);

  cfg_t             cfg;
  logic             s1_valid_q, s1_pin_q;
  logic             out_valid_q;
  logic [CodeW-1:0] click_event_q, button_state_q;
  logic [CodeW-1:0] click_event_d, button_state_d;
  logic             adv;
  logic             in_fire;

  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  bcc_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bcc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (adv),
    .pin_level_i    (s1_pin_q),
    .cfg_i          (cfg),
    .click_event_o  (click_event_d),
    .button_state_o (button_state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pin_q <= pin_level_i;
    end
    if (adv) begin
      click_event_q  <= click_event_d;
      button_state_q <= button_state_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign click_event_o  = click_event_q;
  assign button_state_o = button_state_q;

endmodule

/* rtl/bcc_checker.sv */
module bcc_checker import bcc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [CodeW-1:0]   click_event_o,
  input logic [CodeW-1:0]   button_state_o
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(click_event_o)
      && $stable(button_state_o))
    else $error("result beat changed while stalled");

  // input only backs up when the result side is blocked
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free result register");

  // every event names the state it lands in
  a_event_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (click_event_o == EV_NONE)
      || (click_event_o == EV_SINGLE && button_state_o == ST_IDLE)
      || (click_event_o == EV_DOUBLE && button_state_o == ST_DOUBLE)
      || (click_event_o == EV_LONG_REACH && button_state_o == ST_LONG)
      || (click_event_o == EV_EXTRA_REACH && button_state_o == ST_EXTRA)
      || (click_event_o == EV_LONG_REL && button_state_o == ST_IDLE)
      || (click_event_o == EV_EXTRA_REL && button_state_o == ST_IDLE))
    else $error("click event does not match state");

  // a fresh result comes from a beat that was taken into the input register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without matching input beat");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .click_event_o  (click_event_o),
  .button_state_o (button_state_o)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import bcc_pkg::*;

  localparam int NTicks     = 25;
  localparam int NPhases    = 12;
  localparam int PhaseTicks = 60;
  localparam int CycleLimit = 1000000;
  localparam int MaxReports = 10;

  typedef struct packed {
    click_event_e     ev;
    logic [CodeW-1:0] st;
  } click_res_t;

  typedef struct packed {
    logic             en;
    logic             pin;
    logic             chk;
    click_event_e     ev;
    logic [CodeW-1:0] st;
  } tick_row_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [MsW-1:0]     cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic               pin_level_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [CodeW-1:0]   click_event_o;
  logic [CodeW-1:0]   button_state_o;

  // classifier mirror
  logic             cls_en    = 1'b0;
  logic [MsW-1:0]   cls_dbnc  = DebounceRst;
  logic [MsW-1:0]   cls_gap   = DoubleGapRst;
  logic [MsW-1:0]   cls_long  = LongRst;
  logic [MsW-1:0]   cls_extra = ExtraRst;
  logic [CodeW-1:0] cls_state = ST_BOOT;
  logic [MsW-1:0]   cls_ticks = '0;

  click_res_t exp_clicks[$];
  click_res_t want;
  int err_cnt        = 0;
  int out_cnt        = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_left      = 0;

  // debounce 0, gap 2, long 3, extra 2 once enabled
  tick_row_t tick_rows [NTicks] = '{
    '{1'b0, 1'b1, 1'b1, EV_NONE,        ST_BOOT},
    '{1'b0, 1'b0, 1'b1, EV_NONE,        ST_BOOT},
    '{1'b1, 1'b1, 1'b1, EV_NONE,        ST_BOOT},
    '{1'b1, 1'b0, 1'b1, EV_NONE,        ST_IDLE},
    '{1'b1, 1'b1, 1'b1, EV_NONE,        ST_PRESSED},
    '{1'b1, 1'b1, 1'b0, EV_NONE,        ST_BOOT},
    '{1'b1, 1'b1, 1'b0, EV_NONE,        ST_BOOT},
    '{1'b1, 1'b1, 1'b1, EV_LONG_REACH,  ST_LONG},
    '{1'b1, 1'b1, 1'b0, EV_NONE,        ST_BOOT},
    '{1'b1, 1'b1, 1'b1, EV_EXTRA_REACH, ST_EXTRA},
    '{1'b1, 1'b1, 1'b0, EV_NONE,        ST_BOOT},
    '{1'b1, 1'b0, 1'b1, EV_EXTRA_REL,   ST_IDLE},
    '{1'b1, 1'b1, 1'b0, EV_NONE,        ST_BOOT},
    '{1'b1, 1'b0, 1'b0, EV_NONE,        ST_BOOT},
    '{1'b1, 1'b0, 1'b0, EV_NONE,        ST_BOOT},
    '{1'b1, 1'b0, 1'b1, EV_SINGLE,      ST_IDLE},
    '{1'b1, 1'b1, 1'b0, EV_NONE,        ST_BOOT},
    '{1'b1, 1'b0, 1'b0, EV_NONE,        ST_BOOT},
    '{1'b1, 1'b1, 1'b1, EV_DOUBLE,      ST_DOUBLE},
    '{1'b1, 1'b0, 1'b0, EV_NONE,        ST_BOOT},
    '{1'b1, 1'b1, 1'b0, EV_NONE,        ST_BOOT},
    '{1'b1, 1'b1, 1'b0, EV_NONE,        ST_BOOT},
    '{1'b1, 1'b1, 1'b0, EV_NONE,        ST_BOOT},
    '{1'b1, 1'b1, 1'b1, EV_LONG_REACH,  ST_LONG},
    '{1'b1, 1'b0, 1'b1, EV_LONG_REL,    ST_IDLE}
  };

  button_click_classifier i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .pin_level_i,
    .out_valid_o,
    .out_stall_i,
    .click_event_o,
    .button_state_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic click_res_t classify_tick(input logic pin);
    click_res_t       res;
    logic             settled;
    logic [CodeW-1:0] nxt;
    res.ev = EV_NONE;
    if (cls_en) begin
      if (cls_ticks != '1) cls_ticks = cls_ticks + 1'b1;
      settled = cls_ticks >= cls_dbnc;
      nxt = cls_state;
      case (cls_state)
        ST_BOOT: begin
          if (!pin) nxt = ST_IDLE;
        end
        ST_IDLE: begin
          if (settled && pin) nxt = ST_PRESSED;
        end
        ST_PRESSED: begin
          if (settled) begin
            if (!pin) begin
              nxt = ST_RELEASED;
            end else if (cls_ticks >= cls_long) begin
              res.ev = EV_LONG_REACH;
              nxt = ST_LONG;
            end
          end
        end
        ST_LONG: begin
          if (!pin) begin
            res.ev = EV_LONG_REL;
            nxt = ST_IDLE;
          end else if (cls_ticks >= cls_extra) begin
            res.ev = EV_EXTRA_REACH;
            nxt = ST_EXTRA;
          end
        end
        ST_EXTRA: begin
          if (!pin) begin
            res.ev = EV_EXTRA_REL;
            nxt = ST_IDLE;
          end
        end
        ST_RELEASED: begin
          if (settled) begin
            if (pin) begin
              res.ev = EV_DOUBLE;
              nxt = ST_DOUBLE;
            end else if (cls_ticks >= cls_gap) begin
              res.ev = EV_SINGLE;
              nxt = ST_IDLE;
            end
          end
        end
        ST_DOUBLE: begin
          if (settled && !pin) nxt = ST_IDLE;
        end
        default: begin
          nxt = ST_IDLE;
        end
      endcase
      if (nxt != cls_state) begin
        cls_state = nxt;
        cls_ticks = '0;
      end
    end
    res.st = cls_state;
    return res;
  endfunction

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [MsW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_ENABLE:     cls_en    = data[0];
      REG_DEBOUNCE:   cls_dbnc  = data;
      REG_DOUBLE_GAP: cls_gap   = data;
      REG_LONG:       cls_long  = data;
      REG_EXTRA:      cls_extra = data;
      default: ;
    endcase
  endtask

  task automatic send_pin(input logic pin, input logic chk, input click_event_e ev,
                          input logic [CodeW-1:0] st);
    click_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pin_level_i <= pin;
    do @(posedge clk_i); while (in_stall_o);
    res = classify_tick(pin);
    if (chk) begin
      res.ev = ev;
      res.st = st;
    end
    exp_clicks.push_back(res);
  endtask

  task automatic wait_drained;
    in_valid_i <= 1'b0;
    while (exp_clicks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= MaxReports) $display("%s", msg);
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (exp_clicks.size() == 0) begin
        note_error($sformatf("beat %0d unexpected: click_event %0d button_state %0d",
                             out_cnt, click_event_o, button_state_o));
      end else begin
        want = exp_clicks.pop_front();
        if (click_event_o !== want.ev)
          note_error($sformatf("beat %0d click_event: expected %0d, got %0d",
                               out_cnt, want.ev, click_event_o));
        if (button_state_o !== want.st)
          note_error($sformatf("beat %0d button_state: expected %0d, got %0d",
                               out_cnt, want.st, button_state_o));
      end
      out_cnt++;
    end
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CycleLimit) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : main_seq
    logic [MsW-1:0]     wdata;
    logic [CfgIdxW-1:0] spare_idx;
    logic [MsW-1:0]     dbnc, gap, lng, xtr;
    logic               en, lvl;
    int                 n, left, run;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_write(REG_DEBOUNCE, '0);
    cfg_write(REG_DOUBLE_GAP, 16'd2);
    cfg_write(REG_LONG, 16'd3);
    cfg_write(REG_EXTRA, 16'd2);
    foreach (tick_rows[i]) begin
      if (tick_rows[i].en != cls_en) begin
        wait_drained();
        wdata = MsW'($urandom);
        wdata[0] = tick_rows[i].en;
        cfg_write(REG_ENABLE, wdata);
      end
      send_pin(tick_rows[i].pin, tick_rows[i].chk, tick_rows[i].ev, tick_rows[i].st);
    end

    for (int ph = 0; ph < NPhases; ph++) begin
      wait_drained();
      dbnc = MsW'($urandom_range(4));
      gap  = MsW'($urandom_range(10));
      lng  = MsW'($urandom_range(10));
      xtr  = MsW'($urandom_range(10));
      en   = 1'b1;
      n    = PhaseTicks;
      case (ph)
        1: begin
          dbnc = '0;
          gap  = '0;
          lng  = '0;
          xtr  = '0;
        end
        2: begin
          dbnc = '0;
          gap  = '1;
          lng  = '1;
          xtr  = '1;
        end
        3: begin
          xtr = '1;
        end
        6: begin
          en = 1'b0;
          n  = 20;
        end
        default: ;
      endcase
      spare_idx = CfgIdxW'($urandom_range(int'(REG_EXTRA) + 1, (1 << CfgIdxW) - 1));
      wdata = MsW'($urandom);
      cfg_write(spare_idx, wdata);
      wdata = MsW'($urandom);
      wdata[0] = en;
      cfg_write(REG_ENABLE, wdata);
      cfg_write(REG_DEBOUNCE, dbnc);
      cfg_write(REG_DOUBLE_GAP, gap);
      cfg_write(REG_LONG, lng);
      cfg_write(REG_EXTRA, xtr);
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 65;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 65;
        end
        default: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase
      if (ph == 4) hold_req = 200;
      lvl  = 1'($urandom_range(1));
      left = n;
      while (left > 0) begin
        run = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 30);
        if (run > left) run = left;
        repeat (run) send_pin(lvl, 1'b0, EV_NONE, ST_BOOT);
        left -= run;
        lvl = ~lvl;
      end
    end

    wait_drained();
    if (err_cnt == 0 && exp_clicks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bcc_pkg.sv
rtl/bcc_regs.sv
rtl/bcc_core.sv
rtl/button_click_classifier.sv
rtl/bcc_checker.sv
tb/tb_top.sv
